>>> rtl/gbn_pkg.sv
// Package for the go-back-N sender: sizes, result kinds, opcodes.
// No dependencies.
package gbn_pkg;
   localparam int BufferSlots = 64;
   localparam int Window = 8;
   localparam int PayloadBytes = 20;
   localparam int SeqBits = 16;
   localparam int SlotBits = 6;
   localparam int ByteBits = 5;
   localparam int PayDepth = BufferSlots * PayloadBytes;
   localparam int PayAddrBits = 11;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0, OP_ACK = 2'd1, OP_TICK = 2'd2, OP_READ = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      K_SENT = 3'd0, K_ACCEPT = 3'd1, K_FULL = 3'd2, K_STALE = 3'd3,
      K_CORRUPT = 3'd4, K_ACKOK = 3'd5, K_READ = 3'd6
   } kind_type;

   localparam logic [7:0] RegTimeout = 8'd0;
endpackage

>>> rtl/gbn_store.sv
// Packet memories: payload bytes and per-slot checksums, registered reads.
// Depends on gbn_pkg.
module gbn_store (
   input  logic                           clock,
   input  logic                           pay_we,
   input  logic [gbn_pkg::PayAddrBits-1:0] pay_waddr,
   input  logic [7:0]                     pay_wdata,
   input  logic [gbn_pkg::PayAddrBits-1:0] pay_raddr,
   output logic [7:0]                     pay_rdata,
   input  logic                           chk_we,
   input  logic [gbn_pkg::SlotBits-1:0]   chk_waddr,
   input  logic [31:0]                    chk_wdata,
   input  logic [gbn_pkg::SlotBits-1:0]   chk_raddr,
   output logic [31:0]                    chk_rdata
);
   logic [7:0]  pay_mem [gbn_pkg::PayDepth];
   logic [31:0] chk_mem [gbn_pkg::BufferSlots];

   // payload memory
   always_ff @(posedge clock) begin
      if (pay_we) pay_mem[pay_waddr] <= pay_wdata;
      pay_rdata <= pay_mem[pay_raddr];
   end

   // checksum memory
   always_ff @(posedge clock) begin
      if (chk_we) chk_mem[chk_waddr] <= chk_wdata;
      chk_rdata <= chk_mem[chk_raddr];
   end
endmodule

>>> rtl/go_back_n_sender_unit.sv
// Go-back-N sender top level: control sequencer, registers, result register.
// Depends on gbn_pkg and gbn_store.
// One item at a time. Payload bytes are staged in a 20-byte register file
// and their running sum kept. Unless the buffer is full, the completing
// byte commits the checksum, then copies the staged bytes into the payload
// memory one per cycle before any packet goes out. Each packet sent needs
// one checksum memory read: the S_SEND state issues it and S_OUT loads the
// result, and S_SEND holds while the previous result beat stalls. A read
// issues its memory read at accept and loads the result in S_READ. All
// results go through one output register, and no new item is taken while a
// result beat waits there. No clearing pass after reset.
module go_back_n_sender_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic signed [7:0]  req_payload_byte,
   input  logic [15:0] req_ack_number,
   input  logic signed [15:0] req_ack_seq_value,
   input  logic signed [12:0] req_ack_payload_sum,
   input  logic signed [31:0] req_ack_checksum,
   input  logic [5:0]  req_read_slot,
   input  logic [4:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_packet_seq,
   output logic signed [31:0] rsp_packet_checksum,
   output logic [5:0]  rsp_packet_slot,
   output logic signed [7:0]  rsp_read_byte,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SB = gbn_pkg::SlotBits;
   localparam int QB = gbn_pkg::SeqBits;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SEND = 6'b000010, S_WAIT = 6'b000100,
      S_OUT = 6'b001000, S_READ = 6'b010000, S_COPY = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] timeout_ff;
   logic [QB-1:0] base_ff, base_in, nts_ff, nts_in, end_ff, end_in;
   logic [SB-1:0] bslot_ff, bslot_in, eslot_ff, eslot_in;
   logic [15:0] tcnt_ff, tcnt_in;
   logic        trun_ff, trun_in;
   logic [4:0]  bcnt_ff, bcnt_in;
   logic [31:0] sum_ff, sum_in;
   // staged message bytes and the copy cursor into the payload memory
   logic [7:0]    stage_ff [gbn_pkg::PayloadBytes];
   logic [SB-1:0] wslot_ff, wslot_in;
   logic [4:0]    cidx_ff, cidx_in;
   // send cursor: new packets (advance nts) or resend from base
   logic [QB-1:0] cur_ff, cur_in;
   logic [SB-1:0] cslot_ff, cslot_in;
   logic [3:0]    left_ff, left_in;
   logic          resend_ff, resend_in;
   // issued read pending: seq/slot of packet in flight to checksum memory
   logic [QB-1:0] pseq_ff, pseq_in;
   logic [SB-1:0] pslot_ff, pslot_in;
   logic          rd_oor_ff, rd_oor_in;
   // output register
   logic        ov_ff, ov_in, olast_ff, olast_in;
   logic [2:0]  okind_ff, okind_in;
   logic [15:0] oseq_ff, oseq_in;
   logic [31:0] ochk_ff, ochk_in;
   logic [SB-1:0] oslot_ff, oslot_in;
   logic [7:0]  obyte_ff, obyte_in;

   logic        pay_we, chk_we;
   logic [gbn_pkg::PayAddrBits-1:0] pay_waddr, pay_raddr;
   logic [SB-1:0] chk_raddr;
   logic [7:0]  pay_rdata, pay_wdata;
   logic [31:0] chk_rdata, chk_wdata;

   gbn_store u_store (
      .clock(clock), .pay_we(pay_we), .pay_waddr(pay_waddr),
      .pay_wdata(pay_wdata), .pay_raddr(pay_raddr), .pay_rdata(pay_rdata),
      .chk_we(chk_we), .chk_waddr(eslot_ff), .chk_wdata(chk_wdata),
      .chk_raddr(chk_raddr), .chk_rdata(chk_rdata)
   );

   logic accept, out_free, csr_wr;
   logic [QB-1:0] outst, d_ack, nb;
   logic [QB-1:0] cnt_used;
   logic [31:0] expect_sum;
   logic [10:0] slot_base;
   logic [16:0] tinc;
   logic [15:0] tlim;
   logic can_new;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = {16'd0, timeout_ff};
   assign req_ready = (state_ff == S_IDLE) && !ov_ff;
   assign accept = req_valid && req_ready;
   assign out_free = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_packet_seq = oseq_ff;
   assign rsp_packet_checksum = ochk_ff;
   assign rsp_packet_slot = oslot_ff;
   assign rsp_read_byte = obyte_ff;
   assign rsp_last = olast_ff;

   assign outst = nts_ff - base_ff;
   assign d_ack = req_ack_number - base_ff;
   assign cnt_used = end_ff - base_ff;
   assign expect_sum = 32'(req_ack_seq_value) + 32'(req_ack_number)
                       + 32'(req_ack_payload_sum);
   assign slot_base = 11'(wslot_ff) * 11'(gbn_pkg::PayloadBytes);
   assign pay_waddr = slot_base + 11'(cidx_ff);
   assign pay_wdata = stage_ff[cidx_ff];
   assign pay_raddr = 11'(req_read_slot) * 11'(gbn_pkg::PayloadBytes)
                      + 11'(req_read_index);
   assign chk_raddr = cslot_ff;
   assign tinc = 17'(tcnt_ff) + 17'd1;
   assign tlim = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign chk_wdata = sum_ff + 32'(req_payload_byte);
   // new packet may go out
   assign can_new = ((nts_ff - base_ff) < QB'(gbn_pkg::Window)) && (nts_ff != end_ff);

   always_comb begin
      state_in = state_ff;
      base_in = base_ff; nts_in = nts_ff; end_in = end_ff;
      bslot_in = bslot_ff; eslot_in = eslot_ff;
      tcnt_in = tcnt_ff; trun_in = trun_ff; bcnt_in = bcnt_ff; sum_in = sum_ff;
      wslot_in = wslot_ff; cidx_in = cidx_ff;
      cur_in = cur_ff; cslot_in = cslot_ff; left_in = left_ff; resend_in = resend_ff;
      pseq_in = pseq_ff; pslot_in = pslot_ff; rd_oor_in = rd_oor_ff;
      ov_in = ov_ff && !rsp_ready;
      okind_in = okind_ff; olast_in = olast_ff; oseq_in = oseq_ff;
      ochk_in = ochk_ff; oslot_in = oslot_ff; obyte_in = obyte_ff;
      pay_we = 1'b0; chk_we = 1'b0;
      nb = req_ack_number + QB'(1);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               okind_in = gbn_pkg::K_ACCEPT; oseq_in = '0; ochk_in = '0;
               oslot_in = '0; obyte_in = '0; olast_in = 1'b1;
               case (gbn_pkg::opcode_type'(req_opcode))
                  gbn_pkg::OP_BYTE: begin
                     if (bcnt_ff == 5'(gbn_pkg::PayloadBytes - 1)) begin
                        bcnt_in = '0;
                        sum_in = 32'(end_ff);
                        ov_in = 1'b1;
                        if (cnt_used >= QB'(gbn_pkg::BufferSlots)) begin
                           okind_in = gbn_pkg::K_FULL;
                        end else begin
                           chk_we = 1'b1;
                           end_in = end_ff + QB'(1);
                           eslot_in = eslot_ff + SB'(1);
                           olast_in = !(outst < QB'(gbn_pkg::Window));
                           cur_in = nts_ff; cslot_in = bslot_ff + SB'(outst);
                           resend_in = 1'b0; left_in = '0;
                           wslot_in = eslot_ff; cidx_in = '0;
                           state_in = S_COPY;
                        end
                     end else begin
                        bcnt_in = bcnt_ff + 5'd1;
                        if (bcnt_ff == '0) sum_in = 32'(end_ff) + 32'(req_payload_byte);
                        else sum_in = sum_ff + 32'(req_payload_byte);
                     end
                  end
                  gbn_pkg::OP_ACK: begin
                     ov_in = 1'b1;
                     if (d_ack >= outst) okind_in = gbn_pkg::K_STALE;
                     else if (expect_sum != req_ack_checksum)
                        okind_in = gbn_pkg::K_CORRUPT;
                     else begin
                        okind_in = gbn_pkg::K_ACKOK;
                        base_in = nb;
                        bslot_in = bslot_ff + SB'(d_ack) + SB'(1);
                        tcnt_in = '0;
                        if (nts_ff == nb) begin
                           trun_in = 1'b0;
                           olast_in = (nts_ff == end_ff);
                           cur_in = nts_ff; cslot_in = bslot_ff + SB'(d_ack) + SB'(1);
                           resend_in = 1'b0; left_in = '0;
                           if (nts_ff != end_ff) state_in = S_WAIT;
                        end else trun_in = 1'b1;
                     end
                  end
                  gbn_pkg::OP_TICK: begin
                     if (trun_ff) begin
                        if (tinc >= 17'(tlim)) begin
                           tcnt_in = '0;
                           cur_in = base_ff; cslot_in = bslot_ff; resend_in = 1'b1;
                           left_in = (outst > QB'(gbn_pkg::Window)) ?
                                     4'(gbn_pkg::Window) : 4'(outst);
                           if (outst != '0) state_in = S_SEND;
                        end else tcnt_in = tinc[15:0];
                     end
                  end
                  default: begin
                     okind_in = gbn_pkg::K_READ;
                     rd_oor_in = (req_read_index >= 5'(gbn_pkg::PayloadBytes));
                     state_in = S_READ;
                  end
               endcase
            end
         end
         // copy the staged message into its slot, one byte per cycle
         S_COPY: begin
            pay_we = 1'b1;
            cidx_in = cidx_ff + 5'd1;
            if (cidx_ff == 5'(gbn_pkg::PayloadBytes - 1)) state_in = S_WAIT;
         end
         // wait for the accept or ack result beat to drain, then go sending
         S_WAIT: begin
            if (!ov_in) state_in = S_SEND;
         end
         // issue one checksum read for the packet at the cursor
         S_SEND: begin
            if (resend_ff ? (left_ff == '0) : !can_new) state_in = S_IDLE;
            else if (!ov_in) begin
               pseq_in = cur_ff; pslot_in = cslot_ff;
               cur_in = cur_ff + QB'(1); cslot_in = cslot_ff + SB'(1);
               if (resend_ff) left_in = left_ff - 4'd1;
               else begin
                  if (base_ff == nts_ff && !trun_ff) begin
                     trun_in = 1'b1; tcnt_in = '0;
                  end
                  nts_in = nts_ff + QB'(1);
               end
               state_in = S_OUT;
            end
         end
         // checksum data ready: load result
         S_OUT: begin
            ov_in = 1'b1; okind_in = gbn_pkg::K_SENT;
            oseq_in = 16'(pseq_ff); ochk_in = chk_rdata; oslot_in = pslot_ff;
            obyte_in = '0;
            olast_in = resend_ff ? (left_ff == '0) :
                       !(((nts_ff - base_ff) < QB'(gbn_pkg::Window)) && (nts_ff != end_ff));
            state_in = S_SEND;
         end
         S_READ: begin
            ov_in = 1'b1; olast_in = 1'b1;
            obyte_in = rd_oor_ff ? 8'd0 : pay_rdata;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; timeout_ff <= 16'd20;
         base_ff <= QB'(1); nts_ff <= QB'(1); end_ff <= QB'(1);
         bslot_ff <= SB'(1); eslot_ff <= SB'(1);
         tcnt_ff <= '0; trun_ff <= 1'b0; bcnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr && csr_paddr == gbn_pkg::RegTimeout[1:0])
            timeout_ff <= csr_pwdata[15:0];
         base_ff <= base_in; nts_ff <= nts_in; end_ff <= end_in;
         bslot_ff <= bslot_in; eslot_ff <= eslot_in;
         tcnt_ff <= tcnt_in; trun_ff <= trun_in; bcnt_ff <= bcnt_in; ov_ff <= ov_in;
      end
   end

   // message staging
   always_ff @(posedge clock) begin
      if (accept && req_opcode == gbn_pkg::OP_BYTE) stage_ff[bcnt_ff] <= req_payload_byte;
   end

   // payload registers
   always_ff @(posedge clock) begin
      sum_ff <= sum_in; cur_ff <= cur_in; cslot_ff <= cslot_in;
      wslot_ff <= wslot_in; cidx_ff <= cidx_in;
      left_ff <= left_in; resend_ff <= resend_in; pseq_ff <= pseq_in;
      pslot_ff <= pslot_in; rd_oor_ff <= rd_oor_in;
      okind_ff <= okind_in; olast_ff <= olast_in; oseq_ff <= oseq_in;
      ochk_ff <= ochk_in; oslot_ff <= oslot_in; obyte_ff <= obyte_in;
   end
endmodule
